// ----- sv/gtsc_pkg.sv -----
`default_nettype none

package gtsc_pkg;

    typedef enum logic [1:0] {
        ST_ISLANDED       = 2'd0,
        ST_GOING_TIED     = 2'd1,
        ST_TIED           = 2'd2,
        ST_GOING_ISLANDED = 2'd3
    } t_grid_state;

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_TIE    = 2'd1,
        MODE_ISLAND = 2'd2,
        MODE_UNTIE  = 2'd3
    } t_mode;

    typedef struct packed {
        logic        granted;
        t_grid_state grid_state;
    } t_result;

    localparam int CFG_W  = 16;
    localparam int CFG_AW = 1;
    localparam int OUT_DW = 8;

    localparam logic [CFG_AW-1:0] REG_MAX_PHASE   = 1'd0;
    localparam logic [CFG_AW-1:0] REG_MAX_VOLTAGE = 1'd1;

    localparam logic signed [CFG_W-1:0] MAX_ERR_RESET = 16'sd1024;

endpackage

`default_nettype wire

// ----- sv/gtsc_ring_mem.sv -----
`default_nettype none

module gtsc_ring_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- sv/gtsc_core.sv -----
`default_nettype none

module gtsc_core #(
    parameter int WINDOW      = 16,
    parameter int SAMPLE_BITS = 16,
    localparam int PTR_W = $clog2(WINDOW),
    localparam int MEM_W = 2 * SAMPLE_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_acc,
    input  wire gtsc_pkg::t_mode                 i_mode,
    input  wire logic signed [SAMPLE_BITS-1:0]   i_phase,
    input  wire logic signed [SAMPLE_BITS-1:0]   i_voltage,
    input  wire logic                            i_cfg_we,
    input  wire logic [gtsc_pkg::CFG_AW-1:0]     i_cfg_addr,
    input  wire logic [gtsc_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  wire logic [MEM_W-1:0]                i_old,
    output logic                                 o_mem_we,
    output logic [PTR_W-1:0]                     o_mem_waddr,
    output logic [MEM_W-1:0]                     o_mem_wdata,
    output logic [PTR_W-1:0]                     o_mem_raddr,
    output gtsc_pkg::t_result                    o_res
);

    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
    localparam int SHIFT  = $clog2(WINDOW + 1) - 1;
    localparam int CMP_W  = (SUM_W > gtsc_pkg::CFG_W) ? SUM_W : gtsc_pkg::CFG_W;

    gtsc_pkg::t_grid_state r_state, n_state;
    logic [PTR_W-1:0]  r_ptr, n_ptr, ptr_next;
    logic [FILL_W-1:0] r_fill, n_fill, fill_next;
    logic signed [SUM_W-1:0] r_psum, n_psum, sum_p, old_p;
    logic signed [SUM_W-1:0] r_vsum, n_vsum, sum_v, old_v;
    logic signed [SUM_W-1:0] avg_p, avg_v;
    logic signed [SAMPLE_BITS-1:0] old_ph, old_vo;
    logic signed [gtsc_pkg::CFG_W-1:0] r_max_p, r_max_v;
    logic full, pass, granted;

    assign old_ph = i_old[SAMPLE_BITS-1:0];
    assign old_vo = i_old[MEM_W-1:SAMPLE_BITS];
    assign full   = (r_fill == FILL_W'(WINDOW));
    assign old_p  = full ? SUM_W'(old_ph) : '0;
    assign old_v  = full ? SUM_W'(old_vo) : '0;
    assign sum_p  = r_psum + SUM_W'(i_phase) - old_p;
    assign sum_v  = r_vsum + SUM_W'(i_voltage) - old_v;
    assign avg_p  = sum_p >>> SHIFT;
    assign avg_v  = sum_v >>> SHIFT;
    assign pass   = (CMP_W'(avg_p) < CMP_W'(r_max_p)) && (CMP_W'(avg_v) < CMP_W'(r_max_v));

    assign fill_next = full ? r_fill : r_fill + 1'b1;
    assign ptr_next  = (r_ptr == PTR_W'(WINDOW - 1)) ? '0 : r_ptr + 1'b1;

    always_comb begin
        n_state  = r_state;
        n_ptr    = r_ptr;
        n_fill   = r_fill;
        n_psum   = r_psum;
        n_vsum   = r_vsum;
        granted  = 1'b0;
        o_mem_we = 1'b0;
        if (i_acc) begin
            unique case (i_mode)
                gtsc_pkg::MODE_TIE: begin
                    if (r_state == gtsc_pkg::ST_ISLANDED) begin
                        n_state = gtsc_pkg::ST_GOING_TIED;
                    end
                end
                gtsc_pkg::MODE_ISLAND: begin
                    if (r_state == gtsc_pkg::ST_TIED) begin
                        n_state = gtsc_pkg::ST_GOING_ISLANDED;
                    end
                end
                gtsc_pkg::MODE_UNTIE: begin
                    if (r_state == gtsc_pkg::ST_GOING_ISLANDED) begin
                        n_state = gtsc_pkg::ST_ISLANDED;
                        granted = 1'b1;
                    end
                end
                gtsc_pkg::MODE_SAMPLE: begin
                    if (r_state == gtsc_pkg::ST_GOING_TIED) begin
                        o_mem_we = 1'b1;
                        n_psum   = sum_p;
                        n_vsum   = sum_v;
                        n_fill   = fill_next;
                        n_ptr    = ptr_next;
                        if (fill_next == FILL_W'(WINDOW) && pass) begin
                            n_state = gtsc_pkg::ST_TIED;
                            granted = 1'b1;
                            n_ptr   = '0;
                            n_fill  = '0;
                            n_psum  = '0;
                            n_vsum  = '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gtsc_pkg::ST_ISLANDED;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_fill <= '0;
            r_psum <= '0;
            r_vsum <= '0;
        end else begin
            r_ptr  <= n_ptr;
            r_fill <= n_fill;
            r_psum <= n_psum;
            r_vsum <= n_vsum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_p <= gtsc_pkg::MAX_ERR_RESET;
            r_max_v <= gtsc_pkg::MAX_ERR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                gtsc_pkg::REG_MAX_PHASE:   r_max_p <= i_cfg_wdata;
                gtsc_pkg::REG_MAX_VOLTAGE: r_max_v <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // The read address runs one sample ahead, so the oldest entry is ready when
    // the next sample arrives, and it differs from the entry being written except when a tie resets the pointer.
    assign o_mem_raddr      = n_ptr;
    assign o_mem_waddr      = r_ptr;
    assign o_mem_wdata      = {i_voltage, i_phase};
    assign o_res.granted    = granted;
    assign o_res.grid_state = n_state;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WINDOW))
        else $error("fill count beyond window");

    a_tie_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && granted && n_state == gtsc_pkg::ST_TIED)
        |=> (r_fill == '0 && r_psum == '0 && r_vsum == '0 && r_ptr == '0))
        else $error("tie did not clear the window");

    a_idle_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && i_mode == gtsc_pkg::MODE_SAMPLE && r_state != gtsc_pkg::ST_GOING_TIED)
        |=> ($stable(r_psum) && $stable(r_vsum) && $stable(r_fill)))
        else $error("sample changed the window outside going tied");

    a_grant_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        granted |-> (n_state == gtsc_pkg::ST_TIED || n_state == gtsc_pkg::ST_ISLANDED))
        else $error("grant with unexpected state");

endmodule

`default_nettype wire

// ----- sv/gtsc_out_buf.sv -----
`default_nettype none

module gtsc_out_buf (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_acc,
    input  wire gtsc_pkg::t_result i_res,
    output logic                   o_ready,
    output logic                   o_valid,
    input  wire logic              i_take,
    output gtsc_pkg::t_result      o_res
);

    logic              r_out_v, r_skid_v;
    gtsc_pkg::t_result r_out, r_skid;
    logic              move;

    assign move    = !r_out_v || i_take;
    assign o_ready = !r_skid_v;
    assign o_valid = r_out_v;
    assign o_res   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (move) begin
            r_out_v  <= r_skid_v || i_acc;
            r_skid_v <= 1'b0;
        end else if (i_acc) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out <= r_skid_v ? r_skid : i_res;
        end else if (i_acc) begin
            r_skid <= i_res;
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid stage holds a result ahead of the output stage");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && i_take) |=> (r_out_v && !r_skid_v))
        else $error("skid stage did not drain");

    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !i_take) |=> (r_skid_v && $stable(r_skid)))
        else $error("stalled skid stage changed");

endmodule

`default_nettype wire

// ----- sv/grid_tie_sync_check.sv -----
`default_nettype none

// Grid-tie synchronism checker. Every input transaction yields exactly one
// result transaction carrying the grant flag and the grid state after the item.
// One transaction is accepted per clock cycle while the output stage has room,
// and its result is registered in the output stage. The ring memory sets the
// rate with one write and one prefetched read of the oldest entry per cycle. A
// two-entry output stage keeps input accepted while a result waits downstream.
// No clearing pass follows reset; the fill count guards every read of the ring.
module grid_tie_sync_check #(
    parameter int WINDOW      = 16,
    parameter int SAMPLE_BITS = 16,
    localparam int IN_DW = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // tdata: phase_error, voltage_error
    input  wire logic [IN_DW-1:0]              i_s_axis_tdata,
    // tuser: mode
    input  wire logic [1:0]                    i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // tdata: granted, grid_state
    output logic [gtsc_pkg::OUT_DW-1:0]        o_m_axis_tdata,
    input  wire logic                          i_cfg_we,
    input  wire logic [gtsc_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  wire logic [gtsc_pkg::CFG_W-1:0]    i_cfg_wdata
);

    localparam int PTR_W = $clog2(WINDOW);
    localparam int MEM_W = 2 * SAMPLE_BITS;

    logic                          acc, ready;
    logic signed [SAMPLE_BITS-1:0] phase, voltage;
    logic                          mem_we;
    logic [PTR_W-1:0]              mem_waddr, mem_raddr;
    logic [MEM_W-1:0]              mem_wdata, mem_rdata;
    gtsc_pkg::t_result             res, out_res;

    assign phase   = i_s_axis_tdata[SAMPLE_BITS-1:0];
    assign voltage = i_s_axis_tdata[MEM_W-1:SAMPLE_BITS];
    assign acc     = i_s_axis_tvalid && ready;

    gtsc_ring_mem #(
        .DEPTH (WINDOW),
        .WIDTH (MEM_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    gtsc_core #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc),
        .i_mode      (gtsc_pkg::t_mode'(i_s_axis_tuser)),
        .i_phase     (phase),
        .i_voltage   (voltage),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_old       (mem_rdata),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .o_res       (res)
    );

    gtsc_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_res   (res),
        .o_ready (ready),
        .o_valid (o_m_axis_tvalid),
        .i_take  (i_m_axis_tready),
        .o_res   (out_res)
    );

    assign o_s_axis_tready = ready;
    assign o_m_axis_tdata  = gtsc_pkg::OUT_DW'({out_res.grid_state, out_res.granted});

endmodule

`default_nettype wire

// ----- verif/grid_tie_sync_check_test.sv -----
`default_nettype none

module grid_tie_sync_check_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        gtsc_pkg::t_mode   mode;
        logic [15:0]       phase;
        logic [15:0]       volt;
        bit                typed;
        gtsc_pkg::t_result want;
    } t_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_valid = 1'b0;
    logic [31:0]                   s_data = '0;
    logic [1:0]                    s_user = '0;
    logic                          m_ready = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [gtsc_pkg::CFG_AW-1:0]   cfg_addr = '0;
    logic [gtsc_pkg::CFG_W-1:0]    cfg_wdata = '0;
    wire                           s_ready;
    wire                           m_valid;
    wire  [gtsc_pkg::OUT_DW-1:0]   m_data;

    grid_tie_sync_check dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Tracked copy of the synchronism checker.
    gtsc_pkg::t_grid_state trk_state = gtsc_pkg::ST_ISLANDED;
    logic signed [15:0]    phase_hist [16];
    logic signed [15:0]    volt_hist [16];
    logic [3:0]            hist_ptr = '0;
    int                    hist_fill = 0;
    int                    phase_acc = 0;
    int                    volt_acc = 0;
    logic signed [15:0]    lim_phase = gtsc_pkg::MAX_ERR_RESET;
    logic signed [15:0]    lim_volt = gtsc_pkg::MAX_ERR_RESET;

    gtsc_pkg::t_result pending_results [$];
    t_row              directed_rows [$];
    int                fail_count = 0;
    int                idle_mode = 0;
    int                pressure_req = 0;
    int                pressure_ack = 0;
    int                hold_left = 0;

    function automatic gtsc_pkg::t_result step_grid(gtsc_pkg::t_mode mode,
                                                    logic signed [15:0] ph,
                                                    logic signed [15:0] vo);
        gtsc_pkg::t_result r;
        r.granted = 1'b0;
        case (mode)
            gtsc_pkg::MODE_TIE: begin
                if (trk_state == gtsc_pkg::ST_ISLANDED) trk_state = gtsc_pkg::ST_GOING_TIED;
            end
            gtsc_pkg::MODE_ISLAND: begin
                if (trk_state == gtsc_pkg::ST_TIED) trk_state = gtsc_pkg::ST_GOING_ISLANDED;
            end
            gtsc_pkg::MODE_UNTIE: begin
                if (trk_state == gtsc_pkg::ST_GOING_ISLANDED) begin
                    trk_state = gtsc_pkg::ST_ISLANDED;
                    r.granted = 1'b1;
                end
            end
            default: begin
                if (trk_state == gtsc_pkg::ST_GOING_TIED) begin
                    if (hist_fill == 16) begin
                        phase_acc -= phase_hist[hist_ptr];
                        volt_acc -= volt_hist[hist_ptr];
                    end else begin
                        hist_fill++;
                    end
                    phase_hist[hist_ptr] = ph;
                    volt_hist[hist_ptr] = vo;
                    phase_acc += ph;
                    volt_acc += vo;
                    hist_ptr = hist_ptr + 4'd1;
                    // Window averages round toward minus infinity.
                    if (hist_fill == 16 && (phase_acc >>> 4) < lim_phase
                            && (volt_acc >>> 4) < lim_volt) begin
                        hist_ptr = '0;
                        hist_fill = 0;
                        phase_acc = 0;
                        volt_acc = 0;
                        trk_state = gtsc_pkg::ST_TIED;
                        r.granted = 1'b1;
                    end
                end
            end
        endcase
        r.grid_state = trk_state;
        return r;
    endfunction

    function automatic logic [15:0] pick_error(int lim, int style);
        int v;
        case (style)
            0: v = int'($urandom_range(0, 65535)) - 32768;
            1: v = lim - int'($urandom_range(0, 900)) + int'($urandom_range(0, 400));
            default: v = $urandom_range(0, 1) ? 32767 : -32768;
        endcase
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic int sender_idle_pct();
        return (idle_mode == 1) ? 78 : (idle_mode == 3) ? 11 : 0;
    endfunction

    task automatic send_item(gtsc_pkg::t_mode mode, logic [15:0] ph, logic [15:0] vo,
                             bit typed, gtsc_pkg::t_result want);
        gtsc_pkg::t_result got;
        if (int'($urandom_range(0, 99)) < sender_idle_pct()) begin
            s_valid <= 1'b0;
            do @(posedge i_clk); while (int'($urandom_range(0, 99)) < sender_idle_pct());
        end
        s_valid <= 1'b1;
        s_data <= {vo, ph};
        s_user <= mode;
        do @(posedge i_clk); while (!s_ready);
        got = step_grid(mode, ph, vo);
        pending_results.push_back(typed ? want : got);
    endtask

    task automatic write_limits(logic [15:0] ph_lim, logic [15:0] vo_lim);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_addr <= gtsc_pkg::REG_MAX_PHASE;
        cfg_wdata <= ph_lim;
        @(posedge i_clk);
        cfg_addr <= gtsc_pkg::REG_MAX_VOLTAGE;
        cfg_wdata <= vo_lim;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        lim_phase = ph_lim;
        lim_volt = vo_lim;
    endtask

    task automatic add_row(gtsc_pkg::t_mode mode, logic [15:0] ph, logic [15:0] vo,
                           bit typed, logic g, gtsc_pkg::t_grid_state st);
        t_row row;
        row.mode = mode;
        row.phase = ph;
        row.volt = vo;
        row.typed = typed;
        row.want.granted = g;
        row.want.grid_state = st;
        directed_rows.push_back(row);
    endtask

    task automatic run_random(int count);
        int sent;
        int len;
        int style;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 99) < 75) begin
                send_item(gtsc_pkg::MODE_TIE, 16'($urandom), 16'($urandom), 1'b0,
                          gtsc_pkg::t_result'(0));
                len = $urandom_range(16, 40);
                style = ($urandom_range(0, 9) < 7) ? 1 : $urandom_range(0, 2);
                for (int j = 0; j < len && trk_state == gtsc_pkg::ST_GOING_TIED; j++) begin
                    send_item(gtsc_pkg::MODE_SAMPLE, pick_error(lim_phase, style),
                              pick_error(lim_volt, style), 1'b0, gtsc_pkg::t_result'(0));
                    sent++;
                end
                send_item(gtsc_pkg::MODE_ISLAND, 16'($urandom), 16'($urandom), 1'b0,
                          gtsc_pkg::t_result'(0));
                if ($urandom_range(0, 9) != 0)
                    send_item(gtsc_pkg::MODE_UNTIE, 16'($urandom), 16'($urandom), 1'b0,
                              gtsc_pkg::t_result'(0));
                sent += 3;
            end else begin
                len = $urandom_range(1, 4);
                for (int j = 0; j < len; j++) begin
                    send_item(gtsc_pkg::t_mode'($urandom_range(0, 3)), 16'($urandom),
                              16'($urandom), 1'b0, gtsc_pkg::t_result'(0));
                    sent++;
                end
            end
        end
        s_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        gtsc_pkg::t_result exp_res;
        if (i_rst_n && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction: tdata %h", m_data);
                fail_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (m_data[0] !== exp_res.granted) begin
                    $error("granted: expected %0d, actual %0d", exp_res.granted, m_data[0]);
                    fail_count++;
                end
                if (m_data[2:1] !== exp_res.grid_state) begin
                    $error("grid_state: expected %0d, actual %0d",
                           exp_res.grid_state, m_data[2:1]);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (pressure_req != pressure_ack) begin
            pressure_ack = pressure_req;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= int'($urandom_range(0, 99)) >=
                       ((idle_mode == 2) ? 78 : (idle_mode == 3) ? 11 : 0);
        end
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Illegal requests before any tie, then a window of extreme samples.
        add_row(gtsc_pkg::MODE_SAMPLE, 16'h7fff, 16'h8000, 1, 1'b0, gtsc_pkg::ST_ISLANDED);
        add_row(gtsc_pkg::MODE_ISLAND, 16'h0000, 16'hffff, 1, 1'b0, gtsc_pkg::ST_ISLANDED);
        add_row(gtsc_pkg::MODE_UNTIE, 16'hffff, 16'h0000, 1, 1'b0, gtsc_pkg::ST_ISLANDED);
        add_row(gtsc_pkg::MODE_TIE, 16'h0000, 16'h0000, 1, 1'b0, gtsc_pkg::ST_GOING_TIED);
        add_row(gtsc_pkg::MODE_TIE, 16'h0000, 16'h0000, 1, 1'b0, gtsc_pkg::ST_GOING_TIED);
        add_row(gtsc_pkg::MODE_ISLAND, 16'h0000, 16'h0000, 1, 1'b0, gtsc_pkg::ST_GOING_TIED);
        add_row(gtsc_pkg::MODE_UNTIE, 16'h0000, 16'h0000, 1, 1'b0, gtsc_pkg::ST_GOING_TIED);
        for (int k = 0; k < 15; k++)
            add_row(gtsc_pkg::MODE_SAMPLE, (k < 8) ? 16'h7fff : 16'h8000,
                    (k < 8) ? 16'h8000 : 16'h7fff, 1, 1'b0, gtsc_pkg::ST_GOING_TIED);
        add_row(gtsc_pkg::MODE_SAMPLE, 16'h8000, 16'h7fff, 0, 1'b0, gtsc_pkg::ST_ISLANDED);
        add_row(gtsc_pkg::MODE_TIE, 16'h0000, 16'h0000, 0, 1'b0, gtsc_pkg::ST_ISLANDED);
        add_row(gtsc_pkg::MODE_ISLAND, 16'h0000, 16'h0000, 0, 1'b0, gtsc_pkg::ST_ISLANDED);
        add_row(gtsc_pkg::MODE_UNTIE, 16'h0000, 16'h0000, 0, 1'b0, gtsc_pkg::ST_ISLANDED);
        foreach (directed_rows[i])
            send_item(directed_rows[i].mode, directed_rows[i].phase, directed_rows[i].volt,
                      directed_rows[i].typed, directed_rows[i].want);
        s_valid <= 1'b0;

        for (int p = 1; p <= 6; p++) begin
            case (p)
                1: write_limits(16'h7fff, 16'h7fff);
                2: write_limits(16'h8000, 16'h8000);
                3: write_limits(16'h0000, 16'h0000);
                4: write_limits(16'hfed4, 16'd500);
                5: write_limits(16'($urandom_range(0, 4000) - 2000),
                                16'($urandom_range(0, 4000) - 2000));
                default: write_limits(gtsc_pkg::MAX_ERR_RESET, gtsc_pkg::MAX_ERR_RESET);
            endcase
            idle_mode = (p - 1) % 4;
            if (p == 3) pressure_req++;
            run_random(150);
        end

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
